// ===== rtl/crl_pkg.sv =====
// shared types and fixed field widths for the color region labeler
package crl_pkg;

  localparam int COLOR_W  = 24;
  localparam int CHAN_W   = 8;
  localparam int LABEL_W  = 6;
  localparam int BCOUNT_W = 20;
  localparam int USED_W   = 7;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_UPDATE
  } crl_state_t;

  typedef struct packed {
    logic load;
    logic lookup;
    logic update;
  } crl_cmd_t;

endpackage

// ===== rtl/crl_ram.sv =====
// generic single-write, single-read ram with registered read data
module crl_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/crl_ctrl.sv =====
// sequencer: accept, color lookup, count update
module crl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output crl_pkg::crl_cmd_t cmd
);
  import crl_pkg::*;

  crl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   state_nxt = start ? S_MATCH : S_IDLE;
      S_MATCH:  state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = start ? S_MATCH : S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    busy       = 1'b0;
    cmd.load   = 1'b0;
    cmd.lookup = 1'b0;
    cmd.update = 1'b0;
    unique case (state_r)
      S_IDLE:   cmd.load = start;
      S_MATCH: begin
        busy       = 1'b1;
        cmd.lookup = 1'b1;
      end
      S_UPDATE: begin
        cmd.load   = start;
        cmd.update = 1'b1;
      end
      default:  busy = 1'b0;
    endcase
  end

endmodule

// ===== rtl/crl_datapath.sv =====
// color table, per-label counts, running biggest region and result registers
module crl_datapath #(
  parameter int MAX_REGIONS = 64,
  parameter int COUNT_WIDTH = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  crl_pkg::crl_cmd_t             cmd,
  input  logic [crl_pkg::CHAN_W-1:0]    in_blue,
  input  logic [crl_pkg::CHAN_W-1:0]    in_green,
  input  logic [crl_pkg::CHAN_W-1:0]    in_red,
  input  logic                          in_first_pixel,
  input  logic                          in_last_pixel,
  output logic                          out_valid,
  output logic [crl_pkg::LABEL_W-1:0]   out_region_label,
  output logic                          out_is_new_region,
  output logic                          out_table_overflow,
  output logic                          out_summary_valid,
  output logic [crl_pkg::LABEL_W-1:0]   out_biggest_label,
  output logic [crl_pkg::BCOUNT_W-1:0]  out_biggest_count,
  output logic [crl_pkg::USED_W-1:0]    out_regions_used
);
  import crl_pkg::*;

  localparam int IDX_W = $clog2(MAX_REGIONS);
  localparam int UW    = $clog2(MAX_REGIONS + 1);
  localparam logic [UW-1:0]          USED_FULL = UW'(MAX_REGIONS);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX   = {COUNT_WIDTH{1'b1}};

  // latched pixel
  logic [COLOR_W-1:0] pix_color_r;
  logic               first_r, last_r;

  // table state
  logic [COLOR_W-1:0]     color_mem [MAX_REGIONS];
  logic [UW-1:0]          used_r;
  logic [IDX_W-1:0]       best_label_r;
  logic [COUNT_WIDTH-1:0] best_count_r;

  // lookup results
  logic [IDX_W-1:0] label_r;
  logic             new_r, ovf_r;

  // result registers
  logic                out_valid_r;
  logic [LABEL_W-1:0]  out_label_r, out_blabel_r;
  logic                out_new_r, out_ovf_r, out_sum_r;
  logic [BCOUNT_W-1:0] out_bcount_r;
  logic [USED_W-1:0]   out_used_r;

  // lookup stage signals
  logic [UW-1:0]          used_eff;
  logic [MAX_REGIONS-1:0] match;
  logic [IDX_W-1:0]       hit_idx, label_nxt;
  logic                   found, full, new_nxt;

  // update stage signals
  logic [COUNT_WIDTH-1:0] ram_rdata, cur_cnt, inc_cnt;
  logic [IDX_W-1:0]       best_label_nxt;
  logic [COUNT_WIDTH-1:0] best_count_nxt;
  logic                   take_best;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix_color_r <= {in_red, in_green, in_blue};
      first_r     <= in_first_pixel;
      last_r      <= in_last_pixel;
    end
  end

  // a first pixel sees an empty table
  assign used_eff = first_r ? '0 : used_r;

  // colors in the table are distinct, so at most one entry matches
  always_comb begin
    hit_idx = '0;
    for (int k = 0; k < MAX_REGIONS; k++) begin
      match[k] = (UW'(k) < used_eff) && (color_mem[k] == pix_color_r);
      hit_idx  = hit_idx | (match[k] ? IDX_W'(k) : '0);
    end
  end

  assign found   = |match;
  assign full    = (used_eff == USED_FULL);
  assign new_nxt = !found && !full;

  always_comb begin
    priority if (found) begin
      label_nxt = hit_idx;
    end else if (!full) begin
      label_nxt = used_eff[IDX_W-1:0];
    end else begin
      label_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      label_r <= label_nxt;
      new_r   <= new_nxt;
      ovf_r   <= !found && full;
      if (new_nxt) begin
        color_mem[label_nxt] <= pix_color_r;
      end
    end
  end

  crl_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (MAX_REGIONS)
  ) u_count_ram (
    .clk   (clk),
    .we    (cmd.update && !ovf_r),
    .waddr (label_r),
    .wdata (inc_cnt),
    .raddr (label_nxt),
    .rdata (ram_rdata)
  );

  // a fresh entry starts from zero whatever the ram holds
  assign cur_cnt = new_r ? '0 : ram_rdata;
  assign inc_cnt = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + COUNT_WIDTH'(1);

  assign take_best = !ovf_r && (label_r != '0) &&
                     ((inc_cnt > best_count_r) ||
                      ((inc_cnt == best_count_r) && (label_r < best_label_r)));
  assign best_label_nxt = take_best ? label_r : best_label_r;
  assign best_count_nxt = take_best ? inc_cnt : best_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r       <= '0;
      best_label_r <= '0;
      best_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= cmd.update;
      if (cmd.lookup) begin
        used_r <= used_eff + UW'(new_nxt);
        if (first_r) begin
          best_label_r <= '0;
          best_count_r <= '0;
        end
      end
      if (cmd.update) begin
        best_label_r <= best_label_nxt;
        best_count_r <= best_count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_label_r  <= LABEL_W'(32'(label_r));
      out_new_r    <= new_r;
      out_ovf_r    <= ovf_r;
      out_sum_r    <= last_r;
      out_blabel_r <= last_r ? LABEL_W'(32'(best_label_nxt)) : '0;
      out_bcount_r <= last_r ? BCOUNT_W'(32'(best_count_nxt)) : '0;
      out_used_r   <= USED_W'(32'(used_r));
    end
  end

  assign out_valid          = out_valid_r;
  assign out_region_label   = out_label_r;
  assign out_is_new_region  = out_new_r;
  assign out_table_overflow = out_ovf_r;
  assign out_summary_valid  = out_sum_r;
  assign out_biggest_label  = out_blabel_r;
  assign out_biggest_count  = out_bcount_r;
  assign out_regions_used   = out_used_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_FULL)
    else $error("table fill count beyond table size");

  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.lookup |-> $onehot0(match))
    else $error("color found in more than one table entry");

  a_result_follows_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(cmd.update))
    else $error("result strobe without an update cycle");

  a_new_or_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> !(new_r && ovf_r))
    else $error("pixel both new and overflowed");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.update && ovf_r) |-> (used_r == USED_FULL))
    else $error("overflow flagged while table has room");

endmodule

// ===== rtl/color_region_labeler.sv =====
// top level of the color region labeler
//
//   channel  ports                        transaction when
//   input    start, busy, in_*            rising edge with start high and busy low
//   result   out_valid, out_*             rising edge ending the cycle out_valid is high
//
// a pixel goes through the color table compare, then the count
// read-modify-write through the count ram's registered read port
// busy is high only in the compare cycle, so the next pixel can be accepted during the previous pixel's count update
// the result shows for one cycle, from the result registers loaded at the end of the count update
// after reset the table is empty at once; no clearing pass is needed
// the receiver cannot stall; results are never held back
module color_region_labeler #(
  parameter int MAX_REGIONS = 64,
  parameter int COUNT_WIDTH = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [crl_pkg::CHAN_W-1:0]    in_blue,
  input  logic [crl_pkg::CHAN_W-1:0]    in_green,
  input  logic [crl_pkg::CHAN_W-1:0]    in_red,
  input  logic                          in_first_pixel,
  input  logic                          in_last_pixel,
  output logic                          out_valid,
  output logic [crl_pkg::LABEL_W-1:0]   out_region_label,
  output logic                          out_is_new_region,
  output logic                          out_table_overflow,
  output logic                          out_summary_valid,
  output logic [crl_pkg::LABEL_W-1:0]   out_biggest_label,
  output logic [crl_pkg::BCOUNT_W-1:0]  out_biggest_count,
  output logic [crl_pkg::USED_W-1:0]    out_regions_used
);
  import crl_pkg::*;

  crl_cmd_t cmd;

  crl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  crl_datapath #(
    .MAX_REGIONS (MAX_REGIONS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_blue            (in_blue),
    .in_green           (in_green),
    .in_red             (in_red),
    .in_first_pixel     (in_first_pixel),
    .in_last_pixel      (in_last_pixel),
    .out_valid          (out_valid),
    .out_region_label   (out_region_label),
    .out_is_new_region  (out_is_new_region),
    .out_table_overflow (out_table_overflow),
    .out_summary_valid  (out_summary_valid),
    .out_biggest_label  (out_biggest_label),
    .out_biggest_count  (out_biggest_count),
    .out_regions_used   (out_regions_used)
  );

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the color region labeler: pixel driver, predictor and result monitor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_REGIONS  = 64;
  localparam int COUNT_BITS   = 20;
  localparam int RANDOM_ITEMS = 950;
  localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = '1;

  typedef struct {
    logic [crl_pkg::CHAN_W-1:0] blue;
    logic [crl_pkg::CHAN_W-1:0] green;
    logic [crl_pkg::CHAN_W-1:0] red;
    bit first;
    bit last;
    bit drain;  // sender waits until all results are back before this pixel
  } pixel_t;

  typedef struct {
    logic [crl_pkg::LABEL_W-1:0]  region_label;
    logic                         is_new_region;
    logic                         table_overflow;
    logic                         summary_valid;
    logic [crl_pkg::LABEL_W-1:0]  biggest_label;
    logic [crl_pkg::BCOUNT_W-1:0] biggest_count;
    logic [crl_pkg::USED_W-1:0]   regions_used;
  } label_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [crl_pkg::CHAN_W-1:0] in_blue = '0;
  logic [crl_pkg::CHAN_W-1:0] in_green = '0;
  logic [crl_pkg::CHAN_W-1:0] in_red = '0;
  logic in_first_pixel = 1'b0;
  logic in_last_pixel = 1'b0;
  logic out_valid;
  logic [crl_pkg::LABEL_W-1:0]  out_region_label;
  logic                         out_is_new_region;
  logic                         out_table_overflow;
  logic                         out_summary_valid;
  logic [crl_pkg::LABEL_W-1:0]  out_biggest_label;
  logic [crl_pkg::BCOUNT_W-1:0] out_biggest_count;
  logic [crl_pkg::USED_W-1:0]   out_regions_used;

  color_region_labeler #(
    .MAX_REGIONS(NUM_REGIONS),
    .COUNT_WIDTH(COUNT_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_blue(in_blue),
    .in_green(in_green),
    .in_red(in_red),
    .in_first_pixel(in_first_pixel),
    .in_last_pixel(in_last_pixel),
    .out_valid(out_valid),
    .out_region_label(out_region_label),
    .out_is_new_region(out_is_new_region),
    .out_table_overflow(out_table_overflow),
    .out_summary_valid(out_summary_valid),
    .out_biggest_label(out_biggest_label),
    .out_biggest_count(out_biggest_count),
    .out_regions_used(out_regions_used)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pixel_t        pending_pixels[$];
  label_result_t expected_labels[$];
  pixel_t        held_pixel;
  int            total_pixels;
  int            issued_pixels;
  int            accepted_pixels;
  int            mismatch_count;

  // predictor copy of the color table
  logic [crl_pkg::COLOR_W-1:0] region_colors[NUM_REGIONS];
  logic [COUNT_BITS-1:0]       region_counts[NUM_REGIONS];
  int                          regions_in_use;
  int                          lead_label;
  logic [COUNT_BITS-1:0]       lead_count;

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("mismatch on %s: got %0d, expected %0d", field, got, want);
    mismatch_count++;
  endtask

  function automatic void bump_region(input int k);
    logic [COUNT_BITS-1:0] c;
    c = region_counts[k];
    if (c != COUNT_LIMIT) c = c + COUNT_BITS'(1);
    region_counts[k] = c;
    // lowest label wins a tie, label 0 never leads
    if (k >= 1 && (c > lead_count || (c == lead_count && k < lead_label))) begin
      lead_label = k;
      lead_count = c;
    end
  endfunction

  function automatic label_result_t label_pixel(input pixel_t px);
    label_result_t r;
    logic [crl_pkg::COLOR_W-1:0] color;
    int hit;
    color = {px.red, px.green, px.blue};
    if (px.first) begin
      regions_in_use = 0;
      lead_label = 0;
      lead_count = '0;
    end
    hit = -1;
    for (int k = 0; k < regions_in_use; k++) begin
      if (hit < 0 && region_colors[k] == color) hit = k;
    end
    r = '{default: '0};
    if (hit >= 0) begin
      r.region_label = hit[crl_pkg::LABEL_W-1:0];
      bump_region(hit);
    end else if (regions_in_use < NUM_REGIONS) begin
      r.region_label = regions_in_use[crl_pkg::LABEL_W-1:0];
      r.is_new_region = 1'b1;
      region_colors[regions_in_use] = color;
      region_counts[regions_in_use] = '0;
      regions_in_use++;
      bump_region(regions_in_use - 1);
    end else begin
      r.table_overflow = 1'b1;
    end
    if (px.last) begin
      r.summary_valid = 1'b1;
      r.biggest_label = lead_label[crl_pkg::LABEL_W-1:0];
      r.biggest_count = lead_count;
    end
    r.regions_used = regions_in_use[crl_pkg::USED_W-1:0];
    return r;
  endfunction

  function automatic bit sender_idles();
    if (issued_pixels >= 300 && issued_pixels < 480) return 1'b0;
    return $urandom_range(99) < 28;
  endfunction

  // driver: one transaction per rising edge with start high and busy low
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_labels = {expected_labels, label_pixel(held_pixel)};
        accepted_pixels++;
      end
      if (!start || !busy) begin
        if (pending_pixels.size() > 0 && !(pending_pixels[0].drain && expected_labels.size() > 0)
            && !sender_idles()) begin
          held_pixel = pending_pixels.pop_front();
          issued_pixels++;
          start <= 1'b1;
          in_blue <= held_pixel.blue;
          in_green <= held_pixel.green;
          in_red <= held_pixel.red;
          in_first_pixel <= held_pixel.first;
          in_last_pixel <= held_pixel.last;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed result is checked against the oldest prediction
  always @(posedge clk) begin
    label_result_t want;
    if (rst_n && out_valid) begin
      if (expected_labels.size() == 0) begin
        report_mismatch("unexpected result, label", out_region_label, 0);
      end else begin
        want = expected_labels.pop_front();
        if (out_region_label !== want.region_label)
          report_mismatch("region_label", out_region_label, want.region_label);
        if (out_is_new_region !== want.is_new_region)
          report_mismatch("is_new_region", out_is_new_region, want.is_new_region);
        if (out_table_overflow !== want.table_overflow)
          report_mismatch("table_overflow", out_table_overflow, want.table_overflow);
        if (out_summary_valid !== want.summary_valid)
          report_mismatch("summary_valid", out_summary_valid, want.summary_valid);
        if (out_biggest_label !== want.biggest_label)
          report_mismatch("biggest_label", out_biggest_label, want.biggest_label);
        if (out_biggest_count !== want.biggest_count)
          report_mismatch("biggest_count", out_biggest_count, want.biggest_count);
        if (out_regions_used !== want.regions_used)
          report_mismatch("regions_used", out_regions_used, want.regions_used);
      end
    end
  end

  task automatic queue_pixel(input logic [23:0] rgb, input bit first, input bit last,
                             input bit drain);
    pixel_t px;
    px.red = rgb[23:16];
    px.green = rgb[15:8];
    px.blue = rgb[7:0];
    px.first = first;
    px.last = last;
    px.drain = drain;
    pending_pixels = {pending_pixels, px};
  endtask

  function automatic logic [23:0] random_color();
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(4))
        0: return 24'h000000;
        1: return 24'hffffff;
        2: return 24'hff0000;
        3: return 24'h00ff00;
        default: return 24'h0000ff;
      endcase
    end
    return 24'($urandom());
  endfunction

  initial begin
    logic [23:0] palette[80];
    int palette_n;
    int len;
    int img;
    int guard;
    bit sweep;
    bit drop_first;
    bit drop_last;
    logic [23:0] color;

    regions_in_use = 0;
    lead_label = 0;
    lead_count = '0;
    mismatch_count = 0;
    issued_pixels = 0;
    accepted_pixels = 0;

    // stream starts without a first pixel flag
    queue_pixel(24'h000000, 0, 0, 0);
    queue_pixel(24'hffffff, 0, 0, 0);
    queue_pixel(24'h000000, 0, 1, 0);
    // single pixel image with both flags
    queue_pixel(24'ha53c5a, 1, 1, 0);
    // only label 0 has pixels, so the summary is empty
    queue_pixel(24'hff0000, 1, 0, 0);
    queue_pixel(24'hff0000, 0, 1, 0);
    // tie between labels 1 and 2 goes to the lower one
    queue_pixel(24'h00ff00, 1, 0, 0);
    queue_pixel(24'h0000ff, 0, 0, 0);
    queue_pixel(24'h123456, 0, 0, 0);
    queue_pixel(24'h123456, 0, 0, 0);
    queue_pixel(24'h0000ff, 0, 1, 0);
    queue_pixel(24'h7f80fe, 1, 0, 1);
    queue_pixel(24'h807f01, 0, 0, 0);
    queue_pixel(24'h807f01, 0, 0, 0);
    queue_pixel(24'hffffff, 0, 1, 0);

    // random images; a sweep walks at least as many palette colors as the table holds
    img = 0;
    while (pending_pixels.size() < RANDOM_ITEMS + 15) begin
      sweep = (img == 0) || ($urandom_range(11) == 0);
      if (sweep) begin
        palette_n = $urandom_range(80, 64);
        len = palette_n + $urandom_range(30);
      end else begin
        palette_n = $urandom_range(8, 1);
        len = $urandom_range(40, 1);
      end
      for (int p = 0; p < palette_n; p++) palette[p] = random_color();
      drop_first = (img > 0) && ($urandom_range(9) == 0);
      drop_last = $urandom_range(9) == 0;
      for (int i = 0; i < len; i++) begin
        color = (sweep && i < palette_n) ? palette[i] : palette[$urandom_range(palette_n - 1)];
        queue_pixel(color, i == 0 && !drop_first, i == len - 1 && !drop_last,
                    i == 0 && (img == 0 || $urandom_range(5) == 0));
      end
      if ($urandom_range(7) == 0)
        queue_pixel(random_color(), $urandom_range(1), $urandom_range(1), 0);
      img++;
    end
    total_pixels = pending_pixels.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_pixels < total_pixels) @(posedge clk);
    guard = 0;
    while (expected_labels.size() > 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (expected_labels.size() > 0)
      report_mismatch("results never returned", expected_labels.size(), 0);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit, far above the slowest correct run
  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
